FILE: sv/handle_priority_queue_macros.svh
// assertion helpers for the handle priority queue
`ifndef HANDLE_PRIORITY_QUEUE_MACROS_SVH
`define HANDLE_PRIORITY_QUEUE_MACROS_SVH

// condition implies consequence in the same cycle
`define HPQ_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define HPQ_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/hpq_pkg.sv
package hpq_pkg;

  // field widths fixed by the port list
  localparam int HANDLE_W   = 4;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int PRIO_PORT_W = 32;
  localparam int COUNT_W    = 5;

  // parameter defaults
  localparam int NODES_DEF     = 16;
  localparam int PRIO_BITS_DEF = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd3;

  // control broadcast to every cell
  typedef struct packed {
    logic                ins;
    logic                shl;
    logic                pop;
    logic [HANDLE_W-1:0] id;
  } hpq_ctrl_t;

endpackage

FILE: sv/hpq_cell.sv
module hpq_cell import hpq_pkg::*; #(
  parameter int PW = PRIO_PORT_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hpq_ctrl_t           ctrl,
  input  logic [PW-1:0]       new_prio,
  input  logic                left_valid,
  input  logic [HANDLE_W-1:0] left_handle,
  input  logic [PW-1:0]       left_prio,
  input  logic                right_valid,
  input  logic [HANDLE_W-1:0] right_handle,
  input  logic [PW-1:0]       right_prio,
  input  logic                ge_prev,
  input  logic                hit_prev,
  output logic                valid,
  output logic [HANDLE_W-1:0] handle,
  output logic [PW-1:0]       prio,
  output logic                ge,
  output logic                hit
);

  logic                valid_r, valid_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [PW-1:0]       prio_r, prio_nxt;
  logic                take_new, take_left, take_right;

  // this cell ranks ahead of the new entry
  assign ge  = valid_r && (prio_r >= new_prio);
  // removal point lies at or before this cell
  assign hit = hit_prev || (valid_r && (handle_r == ctrl.id));

  assign take_new   = ctrl.ins && !ge && ge_prev;
  assign take_left  = ctrl.ins && !ge && !ge_prev;
  assign take_right = ctrl.shl && hit;

  // next cell contents
  always_comb begin
    valid_nxt  = valid_r;
    handle_nxt = handle_r;
    prio_nxt   = prio_r;
    if (take_new) begin
      valid_nxt  = 1'b1;
      handle_nxt = ctrl.id;
      prio_nxt   = new_prio;
    end else if (take_left) begin
      valid_nxt  = left_valid;
      handle_nxt = left_handle;
      prio_nxt   = left_prio;
    end else if (take_right) begin
      valid_nxt  = right_valid;
      handle_nxt = right_handle;
      prio_nxt   = right_prio;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    handle_r <= handle_nxt;
    prio_r   <= prio_nxt;
  end

  assign valid  = valid_r;
  assign handle = handle_r;
  assign prio   = prio_r;

endmodule

FILE: sv/handle_priority_queue.sv
// Priority queue of node handles kept as a sorted row of cells, highest first.
// Command channel: a transaction is taken when start is high and busy is low;
// in_command selects insert, pop or remove, with in_node_id and
// in_priority_req as operands. busy stays low, so a command may be issued
// in every cycle.
// Result channel: out_valid is high for exactly one cycle, the cycle after the
// command, carrying out_status, out_popped_id, out_popped_priority and
// out_entry_count. Throughput is one command per cycle:
// every cell compares against the new priority and the matching handle at
// once, and the whole row shifts by one place together.
// Equal priorities leave in arrival order. Inserting a handle already queued
// and removing a handle not queued are refused and flagged in out_status.
// The receiver cannot stall: a result not taken in its cycle is gone.
// Reset (rst_n low, synchronous) empties every cell and clears the map of
// queued handles; the block is ready as soon as reset is released.
module handle_priority_queue import hpq_pkg::*; #(
  parameter int NODES     = NODES_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [HANDLE_W-1:0]    in_node_id,
  input  logic [PRIO_PORT_W-1:0] in_priority_req,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [HANDLE_W-1:0]    out_popped_id,
  output logic [PRIO_PORT_W-1:0] out_popped_priority,
  output logic [COUNT_W-1:0]     out_entry_count
);

  localparam int PW = (PRIO_BITS < PRIO_PORT_W) ? PRIO_BITS : PRIO_PORT_W;
  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);

  logic                accept;
  hpq_ctrl_t           ctrl;
  logic [PW-1:0]       new_prio;
  logic                id_in_range;
  logic [IW-1:0]       id_idx;
  logic [IW-1:0]       head_idx;

  logic                cell_v   [NODES];
  logic [HANDLE_W-1:0] cell_h   [NODES];
  logic [PW-1:0]       cell_p   [NODES];
  logic                cell_ge  [NODES];
  logic                cell_hit [NODES];
  logic [NODES-1:0]    valid_vec;

  logic [NODES-1:0]    queued_r, queued_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [HANDLE_W-1:0] pid_r, pid_nxt;
  logic [PW-1:0]       pprio_r, pprio_nxt;
  logic [COUNT_W-1:0]  ecount_r;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign new_prio = in_priority_req[PW-1:0];

  assign id_in_range = (32'(in_node_id) < NODES);
  assign id_idx      = IW'(in_node_id);
  assign head_idx    = IW'(cell_h[0]);

  // command decode and queue bookkeeping
  always_comb begin
    ctrl       = '0;
    ctrl.id    = in_node_id;
    queued_nxt = queued_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    pid_nxt    = '0;
    pprio_nxt  = '0;
    if (accept) begin
      case (in_command)
        CMD_INSERT: begin
          if (!id_in_range || queued_r[id_idx] || (32'(count_r) >= NODES)) begin
            status_nxt = ST_DUPLICATE;
          end else begin
            ctrl.ins           = 1'b1;
            queued_nxt[id_idx] = 1'b1;
            count_nxt          = count_r + CW'(1);
          end
        end
        CMD_POP: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctrl.shl  = 1'b1;
            ctrl.pop  = 1'b1;
            pid_nxt   = cell_h[0];
            pprio_nxt = cell_p[0];
            if (32'(cell_h[0]) < NODES) begin
              queued_nxt[head_idx] = 1'b0;
            end
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_REMOVE: begin
          if (!id_in_range || !queued_r[id_idx]) begin
            status_nxt = ST_NOT_QUEUED;
          end else begin
            ctrl.shl           = 1'b1;
            queued_nxt[id_idx] = 1'b0;
            count_nxt          = count_r - CW'(1);
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // row of sorted cells, cell 0 holds the head
  for (genvar i = 0; i < NODES; i++) begin : g_cell
    logic                l_v, r_v, ge_in, hit_in;
    logic [HANDLE_W-1:0] l_h, r_h;
    logic [PW-1:0]       l_p, r_p;

    if (i == 0) begin : g_first
      assign l_v    = 1'b0;
      assign l_h    = '0;
      assign l_p    = '0;
      assign ge_in  = 1'b1;
      assign hit_in = ctrl.pop;
    end else begin : g_mid
      assign l_v    = cell_v[i-1];
      assign l_h    = cell_h[i-1];
      assign l_p    = cell_p[i-1];
      assign ge_in  = cell_ge[i-1];
      assign hit_in = cell_hit[i-1];
    end

    if (i == NODES - 1) begin : g_last
      assign r_v = 1'b0;
      assign r_h = '0;
      assign r_p = '0;
    end else begin : g_inner
      assign r_v = cell_v[i+1];
      assign r_h = cell_h[i+1];
      assign r_p = cell_p[i+1];
    end

    hpq_cell #(.PW(PW)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .new_prio     (new_prio),
      .left_valid   (l_v),
      .left_handle  (l_h),
      .left_prio    (l_p),
      .right_valid  (r_v),
      .right_handle (r_h),
      .right_prio   (r_p),
      .ge_prev      (ge_in),
      .hit_prev     (hit_in),
      .valid        (cell_v[i]),
      .handle       (cell_h[i]),
      .prio         (cell_p[i]),
      .ge           (cell_ge[i]),
      .hit          (cell_hit[i])
    );

    assign valid_vec[i] = cell_v[i];
  end

  // queue state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      queued_r    <= queued_nxt;
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pid_r    <= pid_nxt;
    pprio_r  <= pprio_nxt;
    ecount_r <= COUNT_W'(count_nxt);
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_popped_id       = pid_r;
  assign out_popped_priority = PRIO_PORT_W'(pprio_r);
  assign out_entry_count     = ecount_r;

  `include "handle_priority_queue_macros.svh"

  `HPQ_ASSERT_NOW(a_count_match, clk, rst_n, 1'b1, 32'(count_r) == $countones(valid_vec), "entry count differs from occupied cells")
  `HPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, 32'(count_r) <= NODES, "entry count beyond capacity")
  `HPQ_ASSERT_NOW(a_head_ranked, clk, rst_n, cell_v[NODES-1], cell_v[0], "cells not packed toward the head")
  `HPQ_ASSERT_NEXT(a_result_strobe, clk, rst_n, accept, out_valid, "command gave no result strobe")
  `HPQ_ASSERT_NOW(a_empty_count, clk, rst_n, out_valid && (out_status == ST_EMPTY), out_entry_count == '0, "empty status with entries left")

endmodule

FILE: bench/testbench.sv
module testbench;
  import hpq_pkg::*;

  // command code with no operation behind it, only used as noise
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int DEPTH = NODES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1200;

  typedef struct {
    logic [STATUS_W-1:0]    status;
    logic [HANDLE_W-1:0]    popped_id;
    logic [PRIO_PORT_W-1:0] popped_priority;
    logic [COUNT_W-1:0]     entry_count;
  } queue_result_t;

  // shadow of the sorted cells and the queued-handle map
  class queue_scoreboard;
    logic [HANDLE_W-1:0]    cell_id[DEPTH];
    logic [PRIO_PORT_W-1:0] cell_prio[DEPTH];
    bit                     in_queue[DEPTH];
    int                     depth;
    queue_result_t          awaited[$];
    int                     mismatches;

    function new();
      depth = 0;
      mismatches = 0;
      foreach (in_queue[i]) in_queue[i] = 1'b0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // drop the cell at pos and shift later cells forward
    function void close_cell(int pos);
      for (int i = pos; i + 1 < depth; i++) begin
        cell_id[i] = cell_id[i+1];
        cell_prio[i] = cell_prio[i+1];
      end
      depth--;
    endfunction

    // work out the result of one accepted command
    function void note_command(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] id,
                               logic [PRIO_PORT_W-1:0] prio);
      queue_result_t r;
      int pos;
      r.status = ST_OK;
      r.popped_id = '0;
      r.popped_priority = '0;
      case (cmd)
        CMD_INSERT: begin
          if (in_queue[id] || depth >= DEPTH) begin
            r.status = ST_DUPLICATE;
          end else begin
            pos = 0;
            while (pos < depth && cell_prio[pos] >= prio) pos++;
            for (int i = depth; i > pos; i--) begin
              cell_id[i] = cell_id[i-1];
              cell_prio[i] = cell_prio[i-1];
            end
            cell_id[pos] = id;
            cell_prio[pos] = prio;
            depth++;
            in_queue[id] = 1'b1;
          end
        end
        CMD_POP: begin
          if (depth == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped_id = cell_id[0];
            r.popped_priority = cell_prio[0];
            in_queue[cell_id[0]] = 1'b0;
            close_cell(0);
          end
        end
        CMD_REMOVE: begin
          if (!in_queue[id]) begin
            r.status = ST_NOT_QUEUED;
          end else begin
            pos = depth;
            for (int i = 0; i < depth; i++)
              if (pos == depth && cell_id[i] == id) pos = i;
            in_queue[id] = 1'b0;
            if (pos < depth) close_cell(pos);
          end
        end
        default: ;
      endcase
      r.entry_count = COUNT_W'(depth);
      awaited.push_back(r);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(queue_result_t got);
      queue_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d id %0d prio %h count %0d",
                   got.status, got.popped_id, got.popped_priority, got.entry_count);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.popped_id !== want.popped_id ||
          got.popped_priority !== want.popped_priority ||
          got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status %0d/%0d id %0d/%0d prio %h/%h count %0d/%0d",
                   want.status, got.status, want.popped_id, got.popped_id,
                   want.popped_priority, got.popped_priority,
                   want.entry_count, got.entry_count);
      end
    endfunction

    // pick a handle that is or is not queued, -1 if there is none
    function int pick_handle(bit queued);
      int cands[$];
      for (int i = 0; i < DEPTH; i++)
        if (in_queue[i] == queued) cands.push_back(i);
      if (cands.size() == 0) return -1;
      return cands[$urandom_range(0, cands.size() - 1)];
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [CMD_W-1:0]       in_command = CMD_RESERVED;
  logic [HANDLE_W-1:0]    in_node_id = '0;
  logic [PRIO_PORT_W-1:0] in_priority_req = '0;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [HANDLE_W-1:0]    out_popped_id;
  logic [PRIO_PORT_W-1:0] out_popped_priority;
  logic [COUNT_W-1:0]     out_entry_count;

  queue_scoreboard book = new();
  bit              no_gaps = 1'b0;
  int              cycles = 0;

  handle_priority_queue uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_node_id          (in_node_id),
    .in_priority_req     (in_priority_req),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_popped_id       (out_popped_id),
    .out_popped_priority (out_popped_priority),
    .out_entry_count     (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    queue_result_t got;
    if (rst_n && out_valid) begin
      got.status = out_status;
      got.popped_id = out_popped_id;
      got.popped_priority = out_popped_priority;
      got.entry_count = out_entry_count;
      book.check_result(got);
    end
  end

  // issue one command transaction, then idle for a random gap, none when no_gaps is set
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] id,
                       input logic [PRIO_PORT_W-1:0] prio);
    int gap;
    start <= 1'b1;
    in_command <= cmd;
    in_node_id <= id;
    in_priority_req <= prio;
    do @(posedge clk); while (busy);
    book.note_command(cmd, id, prio);
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  function automatic logic [PRIO_PORT_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return PRIO_PORT_W'($urandom_range(0, 7));
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom;
    endcase
  endfunction

  // any handle, drawn at random
  function automatic logic [HANDLE_W-1:0] any_handle();
    return HANDLE_W'($urandom_range(0, 15));
  endfunction

  // one random command, mostly well-formed, with some noise
  task automatic random_command(bit filling);
    int roll;
    int h;
    roll = $urandom_range(0, 99);
    if (roll < (filling ? 60 : 30)) begin
      h = book.pick_handle(1'b0);
      if (h < 0) issue(CMD_INSERT, HANDLE_W'(book.pick_handle(1'b1)), pick_priority());
      else issue(CMD_INSERT, HANDLE_W'(h), pick_priority());
    end else if (roll < 72) begin
      issue(CMD_POP, any_handle(), $urandom);
    end else if (roll < 88) begin
      h = book.pick_handle(1'b1);
      if (h < 0) issue(CMD_REMOVE, any_handle(), $urandom);
      else issue(CMD_REMOVE, HANDLE_W'(h), $urandom);
    end else if (roll < 93) begin
      h = book.pick_handle(1'b1);
      if (h < 0) issue(CMD_POP, any_handle(), $urandom);
      else issue(CMD_INSERT, HANDLE_W'(h), pick_priority());
    end else if (roll < 97) begin
      h = book.pick_handle(1'b0);
      if (h < 0) issue(CMD_POP, any_handle(), $urandom);
      else issue(CMD_REMOVE, HANDLE_W'(h), $urandom);
    end else begin
      issue(CMD_RESERVED, any_handle(), $urandom);
    end
  endtask

  initial begin
    bit filling;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty queue, bad handles, extremes, ties, removal
    issue(CMD_POP, 4'd0, '0);
    issue(CMD_REMOVE, 4'd5, '0);
    issue(CMD_RESERVED, 4'd15, '1);
    issue(CMD_INSERT, 4'd0, '0);
    issue(CMD_INSERT, 4'd15, '1);
    issue(CMD_INSERT, 4'd3, 32'd100);
    issue(CMD_INSERT, 4'd7, 32'd100);
    issue(CMD_INSERT, 4'd9, 32'd100);
    issue(CMD_INSERT, 4'd3, 32'd5);
    issue(CMD_REMOVE, 4'd7, '0);
    issue(CMD_REMOVE, 4'd7, '0);
    issue(CMD_INSERT, 4'd7, 32'h8000_0000);
    issue(CMD_POP, 4'd0, '0);
    issue(CMD_POP, 4'd0, '0);
    issue(CMD_POP, 4'd0, '0);
    issue(CMD_REMOVE, 4'd0, '0);
    issue(CMD_POP, 4'd0, '0);
    issue(CMD_POP, 4'd0, '0);
    issue(CMD_POP, 4'd0, '0);
    drain();

    // random: alternating fill and drain phases, some without idle gaps
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        filling = (n % 200 == 0);
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      if (n % 250 == 125) drain();
      random_command(filling);
    end

    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
